### rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for letter-pair similarity
// Beat layouts for both directions, the controller states and the byte
// classification used when forming letter pairs.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Score format: unsigned Q1.16
  localparam int unsigned QUO_W = 17;
  // Divider step counter, holds QUO_W
  localparam int unsigned STEP_W = 5;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // Command codes
  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] text_byte;
    logic       end_of_string;
  } lps_in_t;

  typedef struct packed {
    logic [16:0] similarity;
    logic [6:0]  shared_pairs;
    logic [7:0]  pair_total;
    logic        no_pairs;
    logic        capacity_exceeded;
  } lps_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV
  } lps_state_e;

  // A space or a zero byte never takes part in a pair
  function automatic logic is_gap(input logic [7:0] b);
    is_gap = (b == SPACE_BYTE) || (b == NUL_BYTE);
  endfunction

endpackage

### rtl/letter_pair_similarity.sv
// ----------------------------------------------------------------------------
// letter_pair_similarity: Dice-coefficient letter-pair similarity
// Stores letter pairs of the first string in a RAM, lets each pair of the
// second string claim one matching stored pair, and reports the score.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------
//  input    | start_i / busy_o | in_i  : command, text_byte, end_of_string
//  result   | valid_o (strobe) | res_o : similarity, shared_pairs,
//           |                  |         pair_total, no_pairs,
//           |                  |         capacity_exceeded
//
// A first-string byte is stored without leaving idle. A second-string byte that
// forms a pair scans the pair RAM one entry per cycle through the single RAM
// read port. The closing second-string byte then starts the bit-serial score
// divider, and once it is done the result beat shows for one cycle.
// Reset clears all counters; the pair RAM needs no clearing, since only
// entries below the stored count are ever read. Results cannot be stalled.
// ----------------------------------------------------------------------------
module letter_pair_similarity
  import lps_pkg::*;
#(
  parameter int unsigned MAX_PAIRS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  lps_in_t  in_i,
  output logic     valid_o,
  output lps_out_t res_o
);

  localparam int unsigned AW = $clog2(MAX_PAIRS);
  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned TW = CW + 1;

  lps_state_e    state_q, state_d;
  logic [CW-1:0] first_cnt_q, first_cnt_d;
  logic [CW-1:0] second_cnt_q, second_cnt_d;
  logic [CW-1:0] match_q, match_d;
  logic [7:0]    prev_byte_q, prev_byte_d;
  logic          prev_vld_q, prev_vld_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   pair_q, pair_d;
  logic          last_q, last_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] chk_q, chk_d;
  lps_out_t      res_q, res_d;
  logic          valid_q, valid_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [16:0]   ram_wdata, ram_rdata;

  logic             div_start, div_done;
  logic [QUO_W-1:0] div_quo;

  logic          accept;
  logic [15:0]   new_pair;
  logic          pair_ok;
  logic          hit, scan_end;
  logic [TW-1:0] total;
  logic [31:0]   total_ext, match_ext;

  // Pair store: {claimed, first byte, second byte}
  lps_ram #(
    .WIDTH(17),
    .DEPTH(MAX_PAIRS)
  ) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Score divider
  lps_div #(
    .NUM_W(CW),
    .DEN_W(TW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (match_q),
    .den_i  (total),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  assign new_pair  = {prev_byte_q, in_i.text_byte};
  assign pair_ok   = prev_vld_q && !is_gap(prev_byte_q) && !is_gap(in_i.text_byte);
  assign total     = TW'(first_cnt_q) + TW'(second_cnt_q);
  assign total_ext = 32'(total);
  assign match_ext = 32'(match_q);

  // Scan compare on the entry read last cycle
  assign hit      = pend_q && !ram_rdata[16] && (ram_rdata[15:0] == pair_q);
  assign scan_end = pend_q && (CW'(chk_q) == (first_cnt_q - CW'(1)));

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    match_d      = match_q;
    prev_byte_d  = prev_byte_q;
    prev_vld_d   = prev_vld_q;
    ovf_d        = ovf_q;
    pair_d       = pair_q;
    last_d       = last_q;
    iss_d        = iss_q;
    pend_d       = 1'b0;
    chk_d        = chk_q;
    res_d        = res_q;
    valid_d      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = first_cnt_q[AW-1:0];
    ram_wdata    = {1'b0, new_pair};
    ram_re       = 1'b0;
    ram_raddr    = iss_q[AW-1:0];
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          prev_byte_d = in_i.end_of_string ? NUL_BYTE : in_i.text_byte;
          prev_vld_d  = !in_i.end_of_string;
          pair_d      = new_pair;
          last_d      = in_i.end_of_string && (in_i.command == CMD_SECOND);
          iss_d       = '0;
          if (pair_ok && (in_i.command == CMD_FIRST)) begin
            if (first_cnt_q < CW'(MAX_PAIRS)) begin
              ram_we      = 1'b1;
              first_cnt_d = first_cnt_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (pair_ok && (in_i.command == CMD_SECOND)) begin
            if (second_cnt_q < CW'(MAX_PAIRS)) begin
              second_cnt_d = second_cnt_q + CW'(1);
              if (first_cnt_q != '0) begin
                state_d = ST_SCAN;
              end
            end else begin
              ovf_d = 1'b1;
            end
          end
          if ((state_d == ST_IDLE) && in_i.end_of_string &&
              (in_i.command == CMD_SECOND)) begin
            state_d = ST_LOAD;
          end
        end
      end

      ST_SCAN: begin
        if (hit || scan_end) begin
          if (hit) begin
            ram_we    = 1'b1;
            ram_waddr = chk_q;
            ram_wdata = {1'b1, pair_q};
            match_d   = match_q + CW'(1);
          end
          state_d = last_q ? ST_LOAD : ST_IDLE;
        end else begin
          // Issue the next read; data comes back next cycle
          ram_re = (iss_q < first_cnt_q);
          pend_d = ram_re;
          chk_d  = iss_q[AW-1:0];
          iss_d  = iss_q + CW'(1);
        end
      end

      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          res_d.similarity        = (total == '0) ? '0 : div_quo;
          res_d.shared_pairs      = match_ext[6:0];
          res_d.pair_total        = total_ext[7:0];
          res_d.no_pairs          = (total == '0);
          res_d.capacity_exceeded = ovf_q;
          valid_d      = 1'b1;
          // Clear for the next string pair
          first_cnt_d  = '0;
          second_cnt_d = '0;
          match_d      = '0;
          ovf_d        = 1'b0;
          prev_byte_d  = NUL_BYTE;
          prev_vld_d   = 1'b0;
          last_d       = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      match_q      <= '0;
      prev_byte_q  <= NUL_BYTE;
      prev_vld_q   <= 1'b0;
      ovf_q        <= 1'b0;
      last_q       <= 1'b0;
      iss_q        <= '0;
      pend_q       <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      match_q      <= match_d;
      prev_byte_q  <= prev_byte_d;
      prev_vld_q   <= prev_vld_d;
      ovf_q        <= ovf_d;
      last_q       <= last_d;
      iss_q        <= iss_d;
      pend_q       <= pend_d;
      valid_q      <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    chk_q  <= chk_d;
    res_q  <= res_d;
  end

endmodule

### rtl/lps_ram.sv
// ----------------------------------------------------------------------------
// lps_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lps_div.sv
// ----------------------------------------------------------------------------
// lps_div: iterative restoring divider for the score
// Computes floor(num * 2^QUO_W / den) one quotient bit per cycle, assuming
// num < den. After the last step, done_o is high for a cycle.
// ----------------------------------------------------------------------------
module lps_div
  import lps_pkg::*;
#(
  parameter int unsigned NUM_W = 7,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic              active_q, active_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]    rem_q, rem_d;
  logic [DEN_W:0]    den_q, den_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  // One shift-and-subtract step
  assign rem_sh = {rem_q[DEN_W-1:0], 1'b0};
  assign ge     = rem_sh >= den_q;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quo_d    = quo_q;
    done_o   = 1'b0;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = STEP_W'(QUO_W);
      rem_d    = (DEN_W+1)'(num_i);
      den_d    = {1'b0, den_i};
      quo_d    = '0;
    end else if (active_q) begin
      if (cnt_q == '0) begin
        done_o   = 1'b1;
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q - STEP_W'(1);
        rem_d = ge ? (rem_sh - den_q) : rem_sh;
        quo_d = {quo_q[QUO_W-2:0], ge};
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule
